>>> sv/ccsp_pkg.sv
// ============================================================================
// ccsp_pkg
// Shared widths and codes for the conflict checked submatrix place block.
// ============================================================================
package ccsp_pkg;

    // Width of a matrix cell and of a pattern entry.
    localparam int DATA_W = 32;
    // Width of a matrix row/column number held in an index slot.
    localparam int IDX_W = 6;

    // Command codes carried by the func field.
    localparam logic [1:0] FUNC_LOAD_SLOT  = 2'd0;
    localparam logic [1:0] FUNC_LOAD_ENTRY = 2'd1;
    localparam logic [1:0] FUNC_PLACE      = 2'd2;
    localparam logic [1:0] FUNC_READ       = 2'd3;

    // Status codes returned with every result word.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_CONFLICT = 2'd1;
    localparam logic [1:0] STATUS_SIZE     = 2'd2;

endpackage

>>> sv/ccsp_ram.sv
// ============================================================================
// ccsp_ram
// Simple dual-port memory: one write port, one read port with registered data.
// ============================================================================
module ccsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/ccsp_slot_ram.sv
// ============================================================================
// ccsp_slot_ram
// Index slot store: one write port and two registered read ports, so the row
// and the column number of a pattern position are fetched in the same cycle.
// ============================================================================
module ccsp_slot_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [ccsp_pkg::IDX_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr_a,
    input  logic [AW-1:0]             i_raddr_b,
    output logic [ccsp_pkg::IDX_W-1:0] o_rdata_a,
    output logic [ccsp_pkg::IDX_W-1:0] o_rdata_b
);

    logic [ccsp_pkg::IDX_W-1:0] r_mem [DEPTH];
    logic [ccsp_pkg::IDX_W-1:0] r_rdata_a;
    logic [ccsp_pkg::IDX_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> sv/conflict_checked_submatrix_place_top.sv
// ============================================================================
// conflict_checked_submatrix_place_top
// Square result matrix with per-cell written flags; places a small pattern
// through index slots after checking every mapped cell for a conflict.
// ============================================================================
// A command word is taken when start is high and busy is low, and every word
// produces exactly one result word, shown for a single cycle with o_valid
// high; the receiver cannot stall it, so it must take each result as it
// comes. After reset the block sweeps the matrix to zero, one cell per cycle,
// and holds busy high until the sweep is done, before the first command.
// Slot and entry loads keep busy low: one can be given every cycle, and each
// result follows in the next cycle. A read holds busy for one cycle and its
// result passes through the registered read port of the matrix memory and
// then the read state. A place command with a size error or an empty
// pattern answers in the next cycle like a load. Otherwise, with N equal to
// pattern_side squared, the sequencer walks all N pattern positions in a
// check pass (slot fetch, matrix fetch, compare per position), then a write
// pass over the same positions; busy stays high through both passes, and
// the write pass is skipped when the check pass stops on the first conflict.
// ============================================================================
module conflict_checked_submatrix_place_top #(
    parameter int MATRIX_SIDE = 64,
    parameter int PATTERN_MAX = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_func,
    input  logic [3:0]         i_slot_row,
    input  logic [3:0]         i_slot_col,
    input  logic [5:0]         i_matrix_index,
    input  logic signed [31:0] i_entry_value,
    input  logic [4:0]         i_pattern_side,
    input  logic [4:0]         i_index_count,
    input  logic [5:0]         i_cell_row,
    input  logic [5:0]         i_cell_col,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_cell_value,
    output logic               o_cell_used
);

    // Matrix geometry. Each matrix word holds the written flag above the value.
    localparam int CELLS  = MATRIX_SIDE * MATRIX_SIDE;
    localparam int CAW    = $clog2(CELLS);
    localparam int PCELLS = PATTERN_MAX * PATTERN_MAX;
    localparam int PAW    = (PCELLS > 1) ? $clog2(PCELLS) : 1;
    localparam int SAW    = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int MW     = ccsp_pkg::DATA_W + 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CK_ADDR,
        ST_CK_CELL,
        ST_CK_TEST,
        ST_WR_ADDR,
        ST_WR_CELL
    } t_state;

    t_state                      r_state;
    logic [CAW-1:0]              r_clr;
    logic [3:0]                  r_i;
    logic [3:0]                  r_j;
    logic [3:0]                  r_last;
    logic                        r_cell_ok;
    logic [ccsp_pkg::DATA_W-1:0] r_pat;
    logic                        r_rd_ok;
    logic                        r_valid;
    logic [1:0]                  r_status;
    logic [ccsp_pkg::DATA_W-1:0] r_value;
    logic                        r_used;

    logic                        w_acc;
    logic [6:0]                  w_srow_ext;
    logic [6:0]                  w_ri_ext;
    logic [6:0]                  w_rj_ext;
    logic [12:0]                 w_pw_full;
    logic [12:0]                 w_pr_full;
    logic                        w_slot_we;
    logic                        w_pat_we;
    logic [ccsp_pkg::IDX_W-1:0]  w_slot_a;
    logic [ccsp_pkg::IDX_W-1:0]  w_slot_b;
    logic [ccsp_pkg::DATA_W-1:0] w_pat_rdata;
    logic [20:0]                 w_map_full;
    logic [20:0]                 w_in_full;
    logic                        w_map_ok;
    logic                        w_in_ok;
    logic                        w_mat_we;
    logic [CAW-1:0]              w_mat_waddr;
    logic [MW-1:0]               w_mat_wdata;
    logic [CAW-1:0]              w_mat_raddr;
    logic [MW-1:0]               w_mat_rdata;
    logic                        w_conflict;
    logic                        w_last_pos;
    logic                        w_size_err;

    assign busy  = (r_state != ST_IDLE);
    assign w_acc = start && !busy;

    // Load-side addressing, taken straight from the command word.
    assign w_srow_ext = {3'b000, i_slot_row};
    assign w_pw_full  = 13'(i_slot_row) * 13'(PATTERN_MAX) + 13'(i_slot_col);
    assign w_slot_we  = w_acc && (i_func == ccsp_pkg::FUNC_LOAD_SLOT)
                        && (7'(i_slot_row) < 7'(PATTERN_MAX));
    assign w_pat_we   = w_acc && (i_func == ccsp_pkg::FUNC_LOAD_ENTRY)
                        && (7'(i_slot_row) < 7'(PATTERN_MAX))
                        && (7'(i_slot_col) < 7'(PATTERN_MAX));

    // The pattern walk reads slot i (row) and slot j (column) together with
    // pattern entry (i, j); the counters stay put for a whole position.
    assign w_ri_ext  = {3'b000, r_i};
    assign w_rj_ext  = {3'b000, r_j};
    assign w_pr_full = 13'(r_i) * 13'(PATTERN_MAX) + 13'(r_j);

    ccsp_slot_ram #(
        .DEPTH (PATTERN_MAX),
        .AW    (SAW)
    ) u_slots (
        .i_clk     (i_clk),
        .i_we      (w_slot_we),
        .i_waddr   (w_srow_ext[SAW-1:0]),
        .i_wdata   (i_matrix_index),
        .i_raddr_a (w_ri_ext[SAW-1:0]),
        .i_raddr_b (w_rj_ext[SAW-1:0]),
        .o_rdata_a (w_slot_a),
        .o_rdata_b (w_slot_b)
    );

    ccsp_ram #(
        .WIDTH (ccsp_pkg::DATA_W),
        .DEPTH (PCELLS),
        .AW    (PAW)
    ) u_pattern (
        .i_clk   (i_clk),
        .i_we    (w_pat_we),
        .i_waddr (w_pw_full[PAW-1:0]),
        .i_wdata ($unsigned(i_entry_value)),
        .i_raddr (w_pr_full[PAW-1:0]),
        .o_rdata (w_pat_rdata)
    );

    // Mapped cell of the current pattern position, and of a read command.
    // Cells whose row or column falls off the matrix are skipped.
    assign w_map_full = 21'(w_slot_a) * 21'(MATRIX_SIDE) + 21'(w_slot_b);
    assign w_map_ok   = (11'(w_slot_a) < 11'(MATRIX_SIDE))
                        && (11'(w_slot_b) < 11'(MATRIX_SIDE));
    assign w_in_full  = 21'(i_cell_row) * 21'(MATRIX_SIDE) + 21'(i_cell_col);
    assign w_in_ok    = (11'(i_cell_row) < 11'(MATRIX_SIDE))
                        && (11'(i_cell_col) < 11'(MATRIX_SIDE));

    // Matrix port sharing: the reset sweep and the write pass own the write
    // port; the read port serves read commands when idle and the check pass.
    always_comb begin
        w_mat_we    = 1'b0;
        w_mat_waddr = w_map_full[CAW-1:0];
        w_mat_wdata = {1'b1, w_pat_rdata};
        case (r_state)
            ST_CLEAR: begin
                w_mat_we    = 1'b1;
                w_mat_waddr = r_clr;
                w_mat_wdata = '0;
            end
            ST_WR_CELL: begin
                w_mat_we = w_map_ok;
            end
            default: begin
                w_mat_we = 1'b0;
            end
        endcase
    end

    assign w_mat_raddr = (r_state == ST_IDLE) ? w_in_full[CAW-1:0] : w_map_full[CAW-1:0];

    ccsp_ram #(
        .WIDTH (MW),
        .DEPTH (CELLS),
        .AW    (CAW)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_we    (w_mat_we),
        .i_waddr (w_mat_waddr),
        .i_wdata (w_mat_wdata),
        .i_raddr (w_mat_raddr),
        .o_rdata (w_mat_rdata)
    );

    // The one compare step of the check pass: a written cell must already
    // hold exactly the value the pattern would put there.
    assign w_conflict = r_cell_ok && w_mat_rdata[MW-1]
                        && (w_mat_rdata[ccsp_pkg::DATA_W-1:0] != r_pat);
    assign w_last_pos = (r_i == r_last) && (r_j == r_last);
    assign w_size_err = (i_pattern_side != i_index_count)
                        || (7'(i_pattern_side) > 7'(PATTERN_MAX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CAW'(CELLS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_acc) begin
                        r_status <= ccsp_pkg::STATUS_OK;
                        r_value  <= '0;
                        r_used   <= 1'b0;
                        r_i      <= 4'd0;
                        r_j      <= 4'd0;
                        r_last   <= 4'(i_pattern_side - 5'd1);
                        r_rd_ok  <= w_in_ok;
                        case (i_func)
                            ccsp_pkg::FUNC_READ: begin
                                r_state <= ST_READ;
                            end
                            ccsp_pkg::FUNC_PLACE: begin
                                if (w_size_err) begin
                                    r_valid  <= 1'b1;
                                    r_status <= ccsp_pkg::STATUS_SIZE;
                                end else if (i_pattern_side == 5'd0) begin
                                    r_valid <= 1'b1;
                                end else begin
                                    r_state <= ST_CK_ADDR;
                                end
                            end
                            default: begin
                                r_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_READ: begin
                    r_valid <= 1'b1;
                    r_state <= ST_IDLE;
                    if (r_rd_ok) begin
                        r_value <= w_mat_rdata[ccsp_pkg::DATA_W-1:0];
                        r_used  <= w_mat_rdata[MW-1];
                    end
                end
                ST_CK_ADDR: begin
                    r_state <= ST_CK_CELL;
                end
                ST_CK_CELL: begin
                    r_cell_ok <= w_map_ok;
                    r_pat     <= w_pat_rdata;
                    r_state   <= ST_CK_TEST;
                end
                ST_CK_TEST: begin
                    if (w_conflict) begin
                        r_valid  <= 1'b1;
                        r_status <= ccsp_pkg::STATUS_CONFLICT;
                        r_state  <= ST_IDLE;
                    end else if (w_last_pos) begin
                        r_i     <= 4'd0;
                        r_j     <= 4'd0;
                        r_state <= ST_WR_ADDR;
                    end else begin
                        if (r_j == r_last) begin
                            r_j <= 4'd0;
                            r_i <= r_i + 4'd1;
                        end else begin
                            r_j <= r_j + 4'd1;
                        end
                        r_state <= ST_CK_ADDR;
                    end
                end
                ST_WR_ADDR: begin
                    r_state <= ST_WR_CELL;
                end
                ST_WR_CELL: begin
                    if (w_last_pos) begin
                        r_valid <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        if (r_j == r_last) begin
                            r_j <= 4'd0;
                            r_i <= r_i + 4'd1;
                        end else begin
                            r_j <= r_j + 4'd1;
                        end
                        r_state <= ST_WR_ADDR;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_cell_value = $signed(r_value);
    assign o_cell_used  = r_used;

    // A conflict can only be reported straight out of the compare step.
    a_conflict_from_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ccsp_pkg::STATUS_CONFLICT))
        |-> ($past(r_state) == ST_CK_TEST))
        else $error("conflict status without a compare step");

    // A load is answered in the next cycle with a done status.
    a_load_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && ((i_func == ccsp_pkg::FUNC_LOAD_SLOT)
                   || (i_func == ccsp_pkg::FUNC_LOAD_ENTRY)))
        |=> (o_valid && (o_status == ccsp_pkg::STATUS_OK)))
        else $error("load not answered in the next cycle");

    // A read is answered once its data has passed the matrix read register and the read state.
    a_read_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_func == ccsp_pkg::FUNC_READ)) |-> ##2 o_valid)
        else $error("read not answered two cycles after acceptance");

    // The matrix is only written by the reset sweep or the write pass.
    a_matrix_write_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mat_we |-> ((r_state == ST_CLEAR) || (r_state == ST_WR_CELL)))
        else $error("matrix written outside the sweep or the write pass");

endmodule
